### sv/nmzr_pkg.sv
// Shared constants, types and the square-root step for the normal map Z rebuild
`default_nettype none

package nmzr_pkg;

  // channel and arithmetic widths
  localparam int unsigned PixW          = 8;
  localparam int unsigned SqW           = 2 * PixW;
  localparam int unsigned RadW          = 2 * SqW;
  localparam int unsigned RootW         = RadW / 2;
  localparam int unsigned RemW          = RootW + 2;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned SqrtStages    = RootW / StepsPerStage;
  localparam int unsigned SumW          = RootW + 2;
  localparam int unsigned BlueLsb       = RootW / 2 + 1;

  // full-scale byte and the squared radius of the unit disc
  localparam logic [PixW-1:0] FullScale = 8'd255;
  localparam logic [SqW-1:0]  DiscR2    = 16'd65025;
  // 255 in 8.8 fixed point plus the half step of the final shift
  localparam logic [SumW-1:0] RoundBias = 18'd65536;

  // running remainder and partial root of the digit-by-digit square root
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_acc_t;

  // one result bit: bring down two radicand bits and try to subtract 4*root+1
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [RemW+1:0] shifted;
    logic [RemW+1:0] trial;
    logic [RemW+1:0] diff;
    sqrt_acc_t       res;
    shifted = {acc.rem, pair};
    trial   = {2'b00, acc.root, 2'b01};
    diff    = shifted - trial;
    if (shifted >= trial) begin
      res.rem  = diff[RemW-1:0];
      res.root = {acc.root[RootW-2:0], 1'b1};
    end else begin
      res.rem  = shifted[RemW-1:0];
      res.root = {acc.root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/normal_map_z_reconstruct.sv
// Top level: pipelined Z reconstruction of a two-channel normal map pixel
//
// One item (a red, green, alpha pixel) can be accepted in every cycle while
// in_stall_o is low, and it passes through one stage for the optional green
// inversion and the two squares, one for the disc test D = 65025 - u*u - v*v,
// eight stages of the square root of D in 8.8 fixed point (two root bits per
// stage), and the output register that rounds to the blue byte. The whole
// pipeline advances together; it holds while a result waits with out_stall_i
// high, and in_stall_o is raised for exactly those cycles. Pixels outside the
// unit disc give blue 128. invert_green (cfg_wdata_i, taken when cfg_we_i is
// high) selects the inverted green convention and should be written only
// while no item is in flight.
`default_nettype none

module normal_map_z_reconstruct import nmzr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i,
  // input channel
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [PixW-1:0] red_in_i,
  input  wire logic [PixW-1:0] green_in_i,
  input  wire logic [PixW-1:0] alpha_in_i,
  // output channel
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [PixW-1:0]      red_out_o,
  output logic [PixW-1:0]      green_out_o,
  output logic [PixW-1:0]      blue_out_o,
  output logic [PixW-1:0]      alpha_out_o
);

  // configuration register
  logic inv_q;

  // pipeline advance
  logic en;

  // stage a: squares
  logic            vld_a_q;
  logic [PixW-1:0] red_a_q, grn_a_q, alp_a_q;
  logic [SqW-1:0]  usq_a_q, vsq_a_q;
  logic [PixW-1:0] grn_a_d, uabs, vabs;

  // stage 0: disc test, stages 1..SqrtStages: square root
  logic            vld_q [SqrtStages+1];
  logic [PixW-1:0] red_q [SqrtStages+1];
  logic [PixW-1:0] grn_q [SqrtStages+1];
  logic [PixW-1:0] alp_q [SqrtStages+1];
  logic [RadW-1:0] rad_q [SqrtStages+1];
  sqrt_acc_t       acc_q [SqrtStages+1];
  sqrt_acc_t       acc_d [SqrtStages+1];
  logic [SqW:0]    sq_sum;
  logic [SqW-1:0]  d_val;

  // output stage
  logic            out_vld_q;
  logic [PixW-1:0] red_o_q, grn_o_q, blu_o_q, alp_o_q;
  logic [SumW-1:0] blue_sum;
  logic [PixW-1:0] blue_d;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (cfg_we_i) begin
      inv_q <= cfg_wdata_i;
    end
  end

  // everything moves unless a finished item is held at the output
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // green inversion and |2x - 255| of both channels
  always_comb begin
    grn_a_d = inv_q ? (FullScale - green_in_i) : green_in_i;
    uabs    = red_in_i[PixW-1] ? ({red_in_i[PixW-2:0], 1'b0} - FullScale)
                               : (FullScale - {red_in_i[PixW-2:0], 1'b0});
    vabs    = grn_a_d[PixW-1]  ? ({grn_a_d[PixW-2:0], 1'b0} - FullScale)
                               : (FullScale - {grn_a_d[PixW-2:0], 1'b0});
  end

  // disc test: D clamps to zero outside the unit disc
  always_comb begin
    sq_sum = {1'b0, usq_a_q} + {1'b0, vsq_a_q};
    d_val  = (sq_sum >= {1'b0, DiscR2}) ? '0 : (DiscR2 - sq_sum[SqW-1:0]);
  end

  // two root bits per square-root stage
  always_comb begin
    acc_d[0] = '0;
    for (int k = 1; k <= SqrtStages; k++) begin
      acc_d[k] = acc_q[k-1];
      for (int j = 0; j < StepsPerStage; j++) begin
        acc_d[k] = sqrt_step(acc_d[k], rad_q[k-1][RadW-1-2*j -: 2]);
      end
    end
  end

  // rounding of (sqrt(D) + 255) / 2 with saturation
  always_comb begin
    blue_sum = {2'b00, acc_q[SqrtStages].root} + RoundBias;
    blue_d   = blue_sum[SumW-1] ? FullScale : blue_sum[SumW-2:BlueLsb];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k <= SqrtStages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_a_q   <= in_valid_i;
      vld_q[0]  <= vld_a_q;
      for (int k = 1; k <= SqrtStages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[SqrtStages];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      red_a_q  <= red_in_i;
      grn_a_q  <= grn_a_d;
      alp_a_q  <= alpha_in_i;
      usq_a_q  <= {{PixW{1'b0}}, uabs} * {{PixW{1'b0}}, uabs};
      vsq_a_q  <= {{PixW{1'b0}}, vabs} * {{PixW{1'b0}}, vabs};

      red_q[0] <= red_a_q;
      grn_q[0] <= grn_a_q;
      alp_q[0] <= alp_a_q;
      rad_q[0] <= {d_val, {SqW{1'b0}}};
      acc_q[0] <= acc_d[0];
      for (int k = 1; k <= SqrtStages; k++) begin
        red_q[k] <= red_q[k-1];
        grn_q[k] <= grn_q[k-1];
        alp_q[k] <= alp_q[k-1];
        rad_q[k] <= rad_q[k-1] << (2 * StepsPerStage);
        acc_q[k] <= acc_d[k];
      end

      red_o_q  <= red_q[SqrtStages];
      grn_o_q  <= grn_q[SqrtStages];
      blu_o_q  <= blue_d;
      alp_o_q  <= alp_q[SqrtStages];
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_out_o   = red_o_q;
  assign green_out_o = grn_o_q;
  assign blue_out_o  = blu_o_q;
  assign alpha_out_o = alp_o_q;

  // blue never drops below the mid code, since the root is never negative
  a_blue_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (blu_o_q >= 8'd128))
    else $error("blue below mid code");

  // the finished root never exceeds 255 in 8.8 fixed point
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SqrtStages] |-> (acc_q[SqrtStages].root <= 16'd65280))
    else $error("root out of range");

  // the remainder stays within 2*root, so the root is the floor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SqrtStages] |->
      ({1'b0, acc_q[SqrtStages].rem} <= {1'b0, acc_q[SqrtStages].root, 1'b0}))
    else $error("square root remainder too large");

  // a finished item moves into the output register when the pipe advances
  a_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[SqrtStages] && en) |=> out_vld_q)
    else $error("item lost before output");

endmodule

`default_nettype wire

### tb/sv/normal_map_z_reconstruct_checker.sv
// Scoreboard for the normal map Z rebuild: predicts each pixel and compares results
`timescale 1ns / 100ps

module normal_map_z_reconstruct_checker import nmzr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i,
  input  wire logic            in_valid_i,
  input  wire logic            in_stall_i,
  input  wire logic [PixW-1:0] red_in_i,
  input  wire logic [PixW-1:0] green_in_i,
  input  wire logic [PixW-1:0] alpha_in_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_stall_i,
  input  wire logic [PixW-1:0] red_out_i,
  input  wire logic [PixW-1:0] green_out_i,
  input  wire logic [PixW-1:0] blue_out_i,
  input  wire logic [PixW-1:0] alpha_out_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int Full = 255;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic [PixW-1:0] alpha;
  } rgba_t;

  rgba_t rebuilt_q[$];
  bit    green_flip = 1'b0;
  int    mismatch_cnt = 0;

  // largest r with r*r <= x, built from the top bit down
  function automatic logic [31:0] floor_root(logic [31:0] x);
    logic [31:0] root;
    logic [31:0] cand;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (32'd1 << b);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  // expected output pixel for one input pixel under the current green convention
  function automatic rgba_t rebuild_normal(logic [PixW-1:0] r, logic [PixW-1:0] g,
                                           logic [PixW-1:0] a, bit flip);
    rgba_t       px;
    logic [7:0]  gy;
    int          u;
    int          v;
    int          d;
    logic [31:0] s;
    logic [31:0] z;
    gy = flip ? 8'(Full - int'(g)) : g;
    u  = 2 * int'(r) - Full;
    v  = 2 * int'(gy) - Full;
    d  = Full * Full - u * u - v * v;
    if (d < 0) d = 0;
    s  = floor_root(32'(d) << 16);
    // (sqrt(D) + 255) / 2 rounded, with sqrt(D) in 8.8
    z  = (s + 32'(Full << 8) + 32'd256) >> 9;
    if (z > Full) z = Full;
    px.red   = r;
    px.green = gy;
    px.blue  = z[7:0];
    px.alpha = a;
    return px;
  endfunction

  task automatic compare_field(string fld, logic [PixW-1:0] want, logic [PixW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, want, got);
      mismatch_cnt++;
    end
  endtask

  // track the register, queue predictions, check results in order
  always @(posedge clk_i) begin
    rgba_t want;
    if (!rst_ni) begin
      green_flip = 1'b0;
      rebuilt_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        rebuilt_q.push_back(rebuild_normal(red_in_i, green_in_i, alpha_in_i, green_flip));
      if (cfg_we_i) green_flip = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (rebuilt_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual r %0d g %0d b %0d a %0d",
                   $time, red_out_i, green_out_i, blue_out_i, alpha_out_i);
          mismatch_cnt++;
        end else begin
          want = rebuilt_q.pop_front();
          compare_field("red", want.red, red_out_i);
          compare_field("green", want.green, green_out_i);
          compare_field("blue", want.blue, blue_out_i);
          compare_field("alpha", want.alpha, alpha_out_i);
        end
      end
    end
    pending_o <= rebuilt_q.size();
    errors_o  <= mismatch_cnt;
  end

endmodule

### tb/sv/normal_map_z_reconstruct_tb.sv
// Stimulus and verdict for the normal map Z rebuild pipeline
`timescale 1ns / 100ps

module normal_map_z_reconstruct_tb import nmzr_pkg::*; ();

  localparam int PipeDepth  = 11;
  localparam int HoldCycles = 60;
  localparam int IdleLimit  = 1000;

  logic            clk_i;
  logic            rst_n       = 1'b0;
  logic            cfg_we_q    = 1'b0;
  logic            cfg_wdata_q = 1'b0;
  logic            in_valid_q  = 1'b0;
  logic            in_stall_o;
  logic [PixW-1:0] red_q       = '0;
  logic [PixW-1:0] green_q     = '0;
  logic [PixW-1:0] alpha_q     = '0;
  logic            out_valid_o;
  logic            out_stall_q = 1'b0;
  logic [PixW-1:0] red_out_o;
  logic [PixW-1:0] green_out_o;
  logic [PixW-1:0] blue_out_o;
  logic [PixW-1:0] alpha_out_o;

  int mismatches;
  int in_flight;
  int idle_cycles = 0;
  int sent_cnt[2] = '{0, 0};
  bit cur_flip    = 1'b0;
  bit tx_idle_en  = 1'b0;
  bit rx_idle_en  = 1'b0;
  bit hold_req    = 1'b0;

  normal_map_z_reconstruct dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we_q),
    .cfg_wdata_i(cfg_wdata_q),
    .in_valid_i (in_valid_q),
    .in_stall_o (in_stall_o),
    .red_in_i   (red_q),
    .green_in_i (green_q),
    .alpha_in_i (alpha_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_q),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .alpha_out_o(alpha_out_o)
  );

  normal_map_z_reconstruct_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we_q),
    .cfg_wdata_i(cfg_wdata_q),
    .in_valid_i (in_valid_q),
    .in_stall_i (in_stall_o),
    .red_in_i   (red_q),
    .green_in_i (green_q),
    .alpha_in_i (alpha_q),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_q),
    .red_out_i  (red_out_o),
    .green_out_i(green_out_o),
    .blue_out_i (blue_out_o),
    .alpha_out_i(alpha_out_o),
    .errors_o   (mismatches),
    .pending_o  (in_flight)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // no progress on either channel for too long ends the run
  always @(posedge clk_i) begin
    if ((in_valid_q && !in_stall_o) || (out_valid_o && !out_stall_q)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no item moved for %0d cycles", IdleLimit);
      $display("normal_map_z_reconstruct regression: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, or one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_q <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_q <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_q <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_q <= 1'b0;
      end
    end
  end

  // offer one pixel and hold it until taken
  task automatic push_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                            input logic [PixW-1:0] a);
    red_q      <= r;
    green_q    <= g;
    alpha_q    <= a;
    in_valid_q <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_cnt[cur_flip]++;
  endtask

  // drop valid and let every pixel in flight come out
  task automatic drain_pipe();
    in_valid_q <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  task automatic set_green_flip(input bit flip);
    cfg_we_q    <= 1'b1;
    cfg_wdata_q <= flip;
    cur_flip     = flip;
    @(posedge clk_i);
    cfg_we_q    <= 1'b0;
  endtask

  // byte biased toward the ends and the middle of the range
  function automatic logic [PixW-1:0] pick_byte();
    logic [PixW-1:0] corner_vals[6];
    corner_vals = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(0, 7) == 0) return corner_vals[$urandom_range(0, 5)];
    return PixW'($urandom_range(0, 255));
  endfunction

  task automatic random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      push_pixel(pick_byte(), pick_byte(), PixW'($urandom_range(0, 255)));
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
        in_valid_q <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  endtask

  // corners, centre, disc edge and the outside of the disc
  task automatic directed_pixels();
    logic [PixW-1:0] rg[12][2];
    logic [PixW-1:0] alphas[4];
    rg = '{'{8'd0, 8'd0}, '{8'd255, 8'd255}, '{8'd0, 8'd255}, '{8'd255, 8'd0},
           '{8'd128, 8'd128}, '{8'd127, 8'd127}, '{8'd127, 8'd128}, '{8'd255, 8'd128},
           '{8'd0, 8'd128}, '{8'd128, 8'd255}, '{8'd128, 8'd0}, '{8'd200, 8'd60}};
    alphas = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    for (int i = 0; i < 12; i++) push_pixel(rg[i][0], rg[i][1], alphas[i % 4]);
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed pixels in both conventions
    set_green_flip(1'b0);
    directed_pixels();
    drain_pipe();
    set_green_flip(1'b1);
    directed_pixels();
    drain_pipe();

    // random pixels with idling on both sides
    set_green_flip(1'b0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    random_pixels(400);
    drain_pipe();

    // long receiver hold while pixels keep coming, so the pipe backs up
    set_green_flip(1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req   = 1'b1;
    random_pixels(40);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    random_pixels(400);
    drain_pipe();

    set_green_flip(1'b0);
    random_pixels(300);
    drain_pipe();

    // full rate to the end
    set_green_flip(1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_pixels(300);
    drain_pipe();

    $display("sent %0d pixels with green as is and %0d with green inverted",
             sent_cnt[0], sent_cnt[1]);
    $display("stimulus: corners, disc edge, outside disc, stall bursts, %0d-cycle hold",
             HoldCycles);
    if (mismatches == 0 && in_flight == 0) begin
      $display("normal_map_z_reconstruct regression: pass");
    end else begin
      $display("normal_map_z_reconstruct regression: fail");
    end
    $finish;
  end

endmodule
